>>> hw/rtl/dspe_pkg.sv
// ----------------------------------------------------------------------------
// dspe_pkg: shared types and constants of the dense shortest path engine
// Item layouts, register indexes, reset values, sequencer states and the
// control/status bundles between the sequencer and the vertex unit.
// ----------------------------------------------------------------------------
package dspe_pkg;

	// field widths fixed by the item layout
	localparam int VTX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int DIST_W   = 40;
	localparam int WEIGHT_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INFINITY     = 2'd3;

	localparam logic [CNT_W-1:0]  VCOUNT_RESET = 7'd64;
	localparam logic [DIST_W-1:0] INF_RESET    = 40'd25600000000;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef struct packed {
		logic                command;
		logic [VTX_W-1:0]    row;
		logic [VTX_W-1:0]    column;
		logic [WEIGHT_W-1:0] weight;
	} cmd_item_t;

	typedef struct packed {
		logic [VTX_W-1:0]  vertex;
		logic              has_predecessor;
		logic [VTX_W-1:0]  predecessor;
		logic [DIST_W-1:0] distance;
		logic              last;
	} res_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_SWEEP,
		ST_DRAIN,
		ST_DECIDE,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_WAIT
	} state_t;

	// sequencer to vertex unit
	typedef struct packed {
		logic              clear;       // clear visited and relaxed marks
		logic              mark;        // mark cur visited
		logic              round_start; // restart next-vertex search
		logic              issue;       // start relaxing vertex vtx
		logic [VTX_W-1:0]  vtx;         // vertex read this cycle
		logic [VTX_W-1:0]  cur;         // vertex being expanded
		logic [DIST_W-1:0] base;        // distance of cur
		logic [DIST_W-1:0] inf;         // unreached distance
	} vu_ctl_t;

	// vertex unit to sequencer
	typedef struct packed {
		logic              busy;
		logic              found;
		logic [VTX_W-1:0]  pick;
		logic [DIST_W-1:0] best;
		logic              rd_pv;
		logic [VTX_W-1:0]  rd_pred;
		logic [DIST_W-1:0] rd_dist;
	} vu_stat_t;

endpackage

>>> hw/rtl/dspe_vertex_unit.sv
// ----------------------------------------------------------------------------
// dspe_vertex_unit: per-vertex state and shared relax/compare unit
// Holds distance and predecessor memories, relaxed and visited marks, and a
// two-stage add/compare pipeline that relaxes one vertex per cycle while
// tracking the smallest unvisited distance for the next round.
// ----------------------------------------------------------------------------
module dspe_vertex_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int IDX_W        = 6,
	parameter int STORE_W      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dspe_pkg::vu_ctl_t    ctl,
	input  logic [STORE_W-1:0]   weight_s1,
	output dspe_pkg::vu_stat_t   stat
);

	logic [dspe_pkg::DIST_W-1:0] dist_mem [MAX_VERTICES];
	logic [IDX_W-1:0]            pred_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]     pv_q;
	logic [MAX_VERTICES-1:0]     visited_q;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] cur_idx;

	// stage 1: read data
	logic                        valid_s1;
	logic [IDX_W-1:0]            vtx_s1;
	logic [dspe_pkg::DIST_W-1:0] dist_s1;
	logic [IDX_W-1:0]            pred_s1;
	logic                        pv_s1;

	// stage 2: relax result
	logic                        valid_s2;
	logic                        cand_s2;
	logic                        upd_s2;
	logic [IDX_W-1:0]            vtx_s2;
	logic [dspe_pkg::DIST_W-1:0] new_s2;

	// next-vertex search
	logic                        found_q;
	logic [IDX_W-1:0]            pick_q;
	logic [dspe_pkg::DIST_W-1:0] best_q;

	logic [dspe_pkg::DIST_W-1:0] old_dist;
	logic [dspe_pkg::DIST_W:0]   sum;
	logic                        cand;
	logic                        upd;
	logic [dspe_pkg::DIST_W-1:0] new_dist;

	assign rd_idx  = ctl.vtx[IDX_W-1:0];
	assign cur_idx = ctl.cur[IDX_W-1:0];

	// distance memory: one registered read, one write from stage 2
	always_ff @(posedge clk) begin
		dist_s1 <= dist_mem[rd_idx];
		if (valid_s2 && upd_s2) begin
			dist_mem[vtx_s2] <= new_s2;
		end
	end

	// predecessor memory
	always_ff @(posedge clk) begin
		pred_s1 <= pred_mem[rd_idx];
		if (valid_s2 && upd_s2) begin
			pred_mem[vtx_s2] <= cur_idx;
		end
	end

	// read-side payload
	always_ff @(posedge clk) begin
		vtx_s1 <= rd_idx;
		pv_s1  <= pv_q[rd_idx];
	end

	// relax: an unrelaxed vertex reads as the infinity value
	always_comb begin
		old_dist = pv_s1 ? dist_s1 : ctl.inf;
		sum      = {1'b0, ctl.base} + (dspe_pkg::DIST_W + 1)'(weight_s1);
		cand     = valid_s1 && !visited_q[vtx_s1];
		upd      = cand && ({1'b0, old_dist} > sum);
		new_dist = upd ? sum[dspe_pkg::DIST_W-1:0] : old_dist;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cand_s2 <= cand;
		upd_s2  <= upd;
		vtx_s2  <= vtx_s1;
		new_s2  <= new_dist;
	end

	// relaxed and visited marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q      <= '0;
			visited_q <= '0;
		end else if (ctl.clear) begin
			pv_q      <= '0;
			visited_q <= '0;
		end else begin
			if (valid_s2 && upd_s2) begin
				pv_q[vtx_s2] <= 1'b1;
			end
			if (ctl.mark) begin
				visited_q[cur_idx] <= 1'b1;
			end
		end
	end

	// smallest unvisited distance, strict compare keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else if (ctl.round_start) begin
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= ctl.inf;
		end else if (valid_s2 && cand_s2 && (new_s2 < best_q)) begin
			found_q <= 1'b1;
			pick_q  <= vtx_s2;
			best_q  <= new_s2;
		end
	end

	always_comb begin
		stat.busy    = valid_s1 || valid_s2;
		stat.found   = found_q;
		stat.pick    = dspe_pkg::VTX_W'(pick_q);
		stat.best    = best_q;
		stat.rd_pv   = pv_s1;
		stat.rd_pred = dspe_pkg::VTX_W'(pred_s1);
		stat.rd_dist = dist_s1;
	end

endmodule

>>> hw/rtl/dense_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// dense_shortest_path_engine: Dijkstra search over a dense weight matrix
// Loads edge weights, runs a single-source search and streams the distance
// and predecessor of every vertex.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd): a load item writes one weight into
//   the on-chip matrix and is taken back to back while idle. A run item
//   searches from the configured source, then sends n results (n = vertex_count)
//   on the res channel (res_valid/res_stall/res), vertex 0 first, last set
//   on the final one. cmd_stall is high from a run's acceptance until its
//   last result is taken.
//   Run flow: a setup state, then per round a round start, a sweep with one vertex
//   relaxed per cycle through the shared add/compare unit, a pipeline drain and a
//   decision, at most n rounds; then each result is read from the single read
//   port of the distance memory, loaded into the result register and held until
//   taken before the next is read.
//   A stalled result holds in its register until taken.
//   Reset clears the sequencer and loads the register defaults; the weight
//   matrix holds garbage until written. Write config only while idle.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  dspe_pkg::cmd_item_t                 cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output dspe_pkg::res_item_t                 res,
	input  logic                                cfg_we,
	input  logic [dspe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dspe_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W   = $clog2(MAX_VERTICES);
	localparam int AW      = $clog2(MAX_VERTICES * MAX_VERTICES);
	localparam int STORE_W = (WEIGHT_BITS < dspe_pkg::WEIGHT_W) ? WEIGHT_BITS
	                                                            : dspe_pkg::WEIGHT_W;

	// configuration
	logic [dspe_pkg::CNT_W-1:0]  vcount_q;
	logic [dspe_pkg::VTX_W-1:0]  src_q;
	logic [dspe_pkg::VTX_W-1:0]  tgt_q;
	logic [dspe_pkg::DIST_W-1:0] inf_q;

	// sequencer
	dspe_pkg::state_t            state_q, state_nx;
	logic [dspe_pkg::CNT_W-1:0]  j_q;
	logic [dspe_pkg::VTX_W-1:0]  cur_q;
	logic [dspe_pkg::DIST_W-1:0] base_q;
	dspe_pkg::res_item_t         res_q;

	// weight store
	logic [STORE_W-1:0] wmem [MAX_VERTICES * MAX_VERTICES];
	logic [STORE_W-1:0] weight_s1;
	logic [AW-1:0]      w_waddr;
	logic [AW-1:0]      w_raddr;
	logic               w_we;

	logic [dspe_pkg::CNT_W-1:0]  n_eff;
	logic [dspe_pkg::VTX_W-1:0]  src_eff;
	logic                        cmd_acc;
	logic                        res_acc;
	logic                        j_last;

	dspe_pkg::vu_ctl_t  ctl;
	dspe_pkg::vu_stat_t stat;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= dspe_pkg::VCOUNT_RESET;
			src_q    <= '0;
			tgt_q    <= '0;
			inf_q    <= dspe_pkg::INF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dspe_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data[dspe_pkg::CNT_W-1:0];
				dspe_pkg::REG_SOURCE:       src_q    <= cfg_data[dspe_pkg::VTX_W-1:0];
				dspe_pkg::REG_TARGET:       tgt_q    <= cfg_data[dspe_pkg::VTX_W-1:0];
				dspe_pkg::REG_INFINITY:     inf_q    <= cfg_data[dspe_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// vertex count clamped to 1..MAX_VERTICES, source saturated into range
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = dspe_pkg::CNT_W'(1);
		end else if (vcount_q > dspe_pkg::CNT_W'(MAX_VERTICES)) begin
			n_eff = dspe_pkg::CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q;
		end
		if ({1'b0, src_q} >= n_eff) begin
			src_eff = dspe_pkg::VTX_W'(n_eff - dspe_pkg::CNT_W'(1));
		end else begin
			src_eff = src_q;
		end
	end

	assign j_last  = (j_q == n_eff - dspe_pkg::CNT_W'(1));
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign res_acc = res_valid && !res_stall;

	// weight store: load port and sweep read port
	assign w_we = cmd_acc && (cmd.command == dspe_pkg::CMD_LOAD)
	           && ({1'b0, cmd.row} < dspe_pkg::CNT_W'(MAX_VERTICES))
	           && ({1'b0, cmd.column} < dspe_pkg::CNT_W'(MAX_VERTICES));
	assign w_waddr = AW'(cmd.row[IDX_W-1:0]) * AW'(MAX_VERTICES)
	               + AW'(cmd.column[IDX_W-1:0]);
	assign w_raddr = AW'(cur_q[IDX_W-1:0]) * AW'(MAX_VERTICES)
	               + AW'(j_q[IDX_W-1:0]);

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= cmd.weight[STORE_W-1:0];
		end
		weight_s1 <= wmem[w_raddr];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dspe_pkg::ST_IDLE: begin
				if (cmd_acc && (cmd.command == dspe_pkg::CMD_RUN)) begin
					state_nx = dspe_pkg::ST_INIT;
				end
			end
			dspe_pkg::ST_INIT:  state_nx = dspe_pkg::ST_ROUND;
			dspe_pkg::ST_ROUND: state_nx = dspe_pkg::ST_SWEEP;
			dspe_pkg::ST_SWEEP: begin
				if (j_last) begin
					state_nx = dspe_pkg::ST_DRAIN;
				end
			end
			dspe_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					state_nx = dspe_pkg::ST_DECIDE;
				end
			end
			dspe_pkg::ST_DECIDE: begin
				if ((cur_q == tgt_q) || !stat.found) begin
					state_nx = dspe_pkg::ST_OUT_RD;
				end else begin
					state_nx = dspe_pkg::ST_ROUND;
				end
			end
			dspe_pkg::ST_OUT_RD:   state_nx = dspe_pkg::ST_OUT_LOAD;
			dspe_pkg::ST_OUT_LOAD: state_nx = dspe_pkg::ST_OUT_WAIT;
			dspe_pkg::ST_OUT_WAIT: begin
				if (res_acc) begin
					state_nx = j_last ? dspe_pkg::ST_IDLE : dspe_pkg::ST_OUT_RD;
				end
			end
			default: state_nx = dspe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dspe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// outputs of the sequencer
	always_comb begin
		cmd_stall       = 1'b1;
		res_valid       = 1'b0;
		ctl.clear       = 1'b0;
		ctl.mark        = 1'b0;
		ctl.round_start = 1'b0;
		ctl.issue       = 1'b0;
		ctl.vtx         = dspe_pkg::VTX_W'(j_q);
		ctl.cur         = cur_q;
		ctl.base        = base_q;
		ctl.inf         = inf_q;
		case (state_q)
			dspe_pkg::ST_IDLE:     cmd_stall = 1'b0;
			dspe_pkg::ST_INIT:     ctl.clear = 1'b1;
			dspe_pkg::ST_ROUND: begin
				ctl.mark        = 1'b1;
				ctl.round_start = 1'b1;
			end
			dspe_pkg::ST_SWEEP:    ctl.issue = 1'b1;
			dspe_pkg::ST_OUT_WAIT: res_valid = 1'b1;
			default: ;
		endcase
	end

	// vertex counter, current vertex and its distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			cur_q  <= '0;
			base_q <= '0;
		end else begin
			case (state_q)
				dspe_pkg::ST_INIT: begin
					cur_q  <= src_eff;
					base_q <= '0;
				end
				dspe_pkg::ST_ROUND: j_q <= '0;
				dspe_pkg::ST_SWEEP: j_q <= j_q + dspe_pkg::CNT_W'(1);
				dspe_pkg::ST_DECIDE: begin
					j_q    <= '0;
					cur_q  <= stat.pick;
					base_q <= stat.best;
				end
				dspe_pkg::ST_OUT_WAIT: begin
					if (res_acc) begin
						j_q <= j_q + dspe_pkg::CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result register; the source reads zero, unrelaxed vertices infinity
	always_ff @(posedge clk) begin
		if (state_q == dspe_pkg::ST_OUT_LOAD) begin
			res_q.vertex          <= dspe_pkg::VTX_W'(j_q);
			res_q.has_predecessor <= stat.rd_pv;
			res_q.predecessor     <= stat.rd_pv ? stat.rd_pred : '0;
			if (dspe_pkg::VTX_W'(j_q) == src_eff) begin
				res_q.distance <= '0;
			end else if (stat.rd_pv) begin
				res_q.distance <= stat.rd_dist;
			end else begin
				res_q.distance <= inf_q;
			end
			res_q.last <= j_last;
		end
	end

	assign res = res_q;

	dspe_vertex_unit #(
		.MAX_VERTICES (MAX_VERTICES),
		.IDX_W        (IDX_W),
		.STORE_W      (STORE_W)
	) u_vertex (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.weight_s1 (weight_s1),
		.stat      (stat)
	);

endmodule

>>> tb/dense_shortest_path_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_test: self-checking bench for the path engine
// Loads edge weights, runs searches under many register settings and checks
// every vertex result against a search computed inside the bench. A planning
// copy of the matrix makes sure no search ever uses a weight never loaded.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine_test;
	import dspe_pkg::*;

	localparam int MAX_V         = 64;
	localparam int PREDICT       = 0;	// matrix copy as seen by accepted items
	localparam int PLAN          = 1;	// matrix copy as seen by the generator
	localparam int RANDOM_ITEMS  = 180;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 16;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_item_t             cmd_item  = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_item_t             res_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register copies, written only while the engine is idle
	logic [CNT_W-1:0]  cfg_count    = VCOUNT_RESET;
	logic [VTX_W-1:0]  cfg_source   = '0;
	logic [VTX_W-1:0]  cfg_target   = '0;
	logic [DIST_W-1:0] cfg_infinity = INF_RESET;

	// weight matrix copies and the search outcome per copy
	bit [WEIGHT_W-1:0] edge_weight   [2][MAX_V*MAX_V];
	bit                edge_known    [2][MAX_V*MAX_V];
	logic [DIST_W-1:0] path_dist     [2][MAX_V];
	logic [VTX_W-1:0]  path_pred     [2][MAX_V];
	bit                path_has_pred [2][MAX_V];

	cmd_item_t cmd_pending[$];
	res_item_t expected_vertices[$];

	int   sender_idle_pct = 0;
	int   recv_stall_pct  = 0;
	bit   hold_go         = 1'b0;
	logic long_hold       = 1'b0;

	int mismatch_count  = 0;
	int loads_done      = 0;
	int searches_done   = 0;
	int results_checked = 0;
	int settings_done   = 0;
	int items_queued    = 0;

	dense_shortest_path_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// vertex count as the engine uses it
	function automatic int clamp_count(logic [CNT_W-1:0] count);
		if (count == 0) return 1;
		if (count > MAX_V) return MAX_V;
		return int'(count);
	endfunction

	// Dijkstra over one matrix copy; returns the first unloaded entry read, or -1
	function automatic int solve_paths(int copy, int n);
		bit          visited [MAX_V];
		int          src, cur, pick, missing, idx;
		bit          found;
		logic [63:0] sum, best;
		src = (int'(cfg_source) >= n) ? n - 1 : int'(cfg_source);
		missing = -1;
		for (int j = 0; j < n; j++) begin
			path_dist[copy][j] = cfg_infinity;
			path_pred[copy][j] = '0;
			path_has_pred[copy][j] = 1'b0;
			visited[j] = 1'b0;
		end
		path_dist[copy][src] = '0;
		cur = src;
		for (int round = 0; round < n; round++) begin
			visited[cur] = 1'b1;
			// relax every open vertex through the current one
			for (int j = 0; j < n; j++) begin
				if (!visited[j]) begin
					idx = cur * MAX_V + j;
					if (!edge_known[copy][idx] && missing < 0)
						missing = idx;
					sum = 64'(path_dist[copy][cur]) + 64'(edge_weight[copy][idx]);
					if (64'(path_dist[copy][j]) > sum) begin
						path_dist[copy][j] = sum[DIST_W-1:0];
						path_pred[copy][j] = 6'(cur);
						path_has_pred[copy][j] = 1'b1;
					end
				end
			end
			if (int'(cfg_target) < n && visited[cfg_target])
				break;
			// next vertex: smallest distance below infinity, lowest index on ties
			found = 1'b0;
			best = 64'(cfg_infinity);
			pick = 0;
			for (int j = 0; j < n; j++) begin
				if (!visited[j] && 64'(path_dist[copy][j]) < best) begin
					best = 64'(path_dist[copy][j]);
					pick = j;
					found = 1'b1;
				end
			end
			if (!found)
				break;
			cur = pick;
		end
		return missing;
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return 32'($urandom_range(1, 2048));
		endcase
	endfunction

	function automatic void queue_load(logic [VTX_W-1:0] row, logic [VTX_W-1:0] column,
			logic [WEIGHT_W-1:0] weight);
		cmd_item_t item;
		item.command = CMD_LOAD;
		item.row = row;
		item.column = column;
		item.weight = weight;
		edge_weight[PLAN][{row, column}] = weight;
		edge_known[PLAN][{row, column}] = 1'b1;
		cmd_pending.push_back(item);
		items_queued++;
	endfunction

	// load whatever the search would read unloaded, then queue the search itself
	function automatic void queue_search();
		cmd_item_t item;
		int        missing;
		missing = solve_paths(PLAN, clamp_count(cfg_count));
		while (missing >= 0) begin
			queue_load(6'(missing / MAX_V), 6'(missing % MAX_V), pick_weight());
			missing = solve_paths(PLAN, clamp_count(cfg_count));
		end
		item.command = CMD_RUN;
		item.row = 6'($urandom);
		item.column = 6'($urandom);
		item.weight = $urandom;
		cmd_pending.push_back(item);
		items_queued++;
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
	endtask

	task automatic set_registers(logic [CNT_W-1:0] count, logic [VTX_W-1:0] source,
			logic [VTX_W-1:0] target, logic [DIST_W-1:0] infinity);
		write_register(REG_VERTEX_COUNT, CFG_DATA_W'(count));
		write_register(REG_SOURCE, CFG_DATA_W'(source));
		write_register(REG_TARGET, CFG_DATA_W'(target));
		write_register(REG_INFINITY, CFG_DATA_W'(infinity));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cfg_count = count;
		cfg_source = source;
		cfg_target = target;
		cfg_infinity = infinity;
		settings_done++;
	endtask

	// sender pause: everything taken and every vertex result back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_pending.size() != 0 || cmd_valid || expected_vertices.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: field %s expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// accepted item: update the matrix or expect one result per vertex
	function automatic void track_item(cmd_item_t item);
		res_item_t want;
		int        n;
		if (item.command == CMD_LOAD) begin
			edge_weight[PREDICT][{item.row, item.column}] = item.weight;
			edge_known[PREDICT][{item.row, item.column}] = 1'b1;
			loads_done++;
		end else begin
			n = clamp_count(cfg_count);
			void'(solve_paths(PREDICT, n));
			for (int j = 0; j < n; j++) begin
				want.vertex = 6'(j);
				want.has_predecessor = path_has_pred[PREDICT][j];
				want.predecessor = path_has_pred[PREDICT][j] ? path_pred[PREDICT][j] : '0;
				want.distance = path_dist[PREDICT][j];
				want.last = (j == n - 1);
				expected_vertices.push_back(want);
			end
			searches_done++;
		end
	endfunction

	function automatic void check_vertex(res_item_t got);
		res_item_t want;
		if (expected_vertices.size() == 0) begin
			$display("%0t: vertex result with none expected, actual vertex %0d distance %0h",
				$time, got.vertex, got.distance);
			mismatch_count++;
		end else begin
			want = expected_vertices.pop_front();
			compare_field("vertex", 64'(want.vertex), 64'(got.vertex));
			compare_field("has_predecessor", 64'(want.has_predecessor),
				64'(got.has_predecessor));
			compare_field("predecessor", 64'(want.predecessor), 64'(got.predecessor));
			compare_field("distance", 64'(want.distance), 64'(got.distance));
			compare_field("last", 64'(want.last), 64'(got.last));
			results_checked++;
		end
	endfunction

	// command driver
	always @(posedge clk) begin
		if (arst_n && (!cmd_valid || !cmd_stall)) begin
			if (cmd_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				cmd_item <= cmd_pending.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(posedge clk) begin
		res_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold <= 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_vertex(res_item);
		if (arst_n && cmd_valid && !cmd_stall)
			track_item(cmd_item);
	end

	// stimulus
	initial begin
		logic [CNT_W-1:0]  count;
		logic [VTX_W-1:0]  source, target;
		logic [DIST_W-1:0] infinity;
		int                n, phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: full size, source is target; receiver holds off meanwhile
		hold_go = 1'b1;
		queue_search();
		repeat (8) queue_load(6'($urandom), 6'($urandom), pick_weight());
		wait_idle();

		// zero count gives one vertex, source out of range, field extremes
		set_registers(7'd0, 6'd5, 6'd0, INF_RESET);
		queue_load(6'd63, 6'd63, 32'hFFFF_FFFF);
		queue_load(6'd42, 6'd21, 32'hAAAA_AAAA);
		queue_load(6'd21, 6'd42, 32'h5555_5555);
		queue_load(6'd0, 6'd0, 32'h0);
		queue_search();
		wait_idle();

		// zero infinity, target never visited
		set_registers(7'd4, 6'd3, 6'd63, '0);
		queue_load(6'd3, 6'd0, 32'h0);
		queue_load(6'd3, 6'd1, 32'h5);
		queue_load(6'd3, 6'd2, 32'hFFFF_FFFF);
		queue_search();
		wait_idle();

		// equal distances, saturated source, largest infinity
		set_registers(7'd4, 6'd9, 6'd1, '1);
		queue_load(6'd3, 6'd0, 32'h100);
		queue_load(6'd3, 6'd1, 32'h300);
		queue_load(6'd3, 6'd2, 32'h100);
		queue_load(6'd0, 6'd1, 32'h200);
		queue_load(6'd0, 6'd2, 32'h0);
		queue_load(6'd2, 6'd1, 32'h200);
		queue_search();
		wait_idle();

		// count above range, row 0 is fully loaded already
		set_registers(7'd127, 6'd0, 6'd0, '1);
		queue_search();
		wait_idle();

		// random phases, idling pattern rotating per phase
		for (phase = 0; items_queued < RANDOM_ITEMS; phase++) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			// mostly small graphs; large ones stop after the source round
			case ($urandom_range(9))
				0: count = $urandom_range(1) ? 7'd64 : 7'($urandom_range(9, 127));
				1: count = 7'($urandom_range(1));
				default: count = 7'($urandom_range(2, 8));
			endcase
			n = clamp_count(count);
			source = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(n - 1));
			if (n > 8)
				target = (int'(source) >= n) ? 6'(n - 1) : source;
			else
				target = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(n - 1));
			case ($urandom_range(7))
				0: infinity = '0;
				1: infinity = '1;
				2: infinity = 40'($urandom_range(16, 4096));
				3: infinity = 40'({$urandom, $urandom});
				default: infinity = INF_RESET;
			endcase
			set_registers(count, source, target, infinity);
			repeat (12) begin
				if ($urandom_range(4) == 0)
					queue_search();
				else if ($urandom_range(1))
					queue_load(6'($urandom), 6'($urandom), pick_weight());
				else
					queue_load(6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)), pick_weight());
			end
			queue_search();
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Run covered %0d weight loads and %0d searches under %0d register settings,",
			loads_done, searches_done, settings_done);
		$display("with %0d vertex results compared field by field.", results_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit
	initial begin
		#200000000;
		$display("Timeout waiting for vertex results");
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dspe_pkg.sv
hw/rtl/dspe_vertex_unit.sv
hw/rtl/dense_shortest_path_engine.sv
tb/dense_shortest_path_engine_test.sv
